// ===== rtl/core/lrci_pkg.sv =====
// Shared types, constants and field offsets of the line raster colour interpolation unit.
package lrci_pkg;

    localparam int COORD_BITS  = 11;
    localparam int PITCH_BITS  = 12;
    localparam int ADDR_BITS   = 22;
    localparam int COLOUR_BITS = 8;
    localparam int CHANNELS    = 3;
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int DIV_CNT_BITS = $clog2(COLOUR_BITS);

    localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(640);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam int S_FIELD_BITS = 4 * COORD_BITS + 2 * CHANNELS * COLOUR_BITS;
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 2 * COORD_BITS + ADDR_BITS + CHANNELS * COLOUR_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    localparam int S_START_X_LSB   = 0;
    localparam int S_START_Y_LSB   = COORD_BITS;
    localparam int S_END_X_LSB     = 2 * COORD_BITS;
    localparam int S_END_Y_LSB     = 3 * COORD_BITS;
    localparam int S_START_COL_LSB = 4 * COORD_BITS;
    localparam int S_END_COL_LSB   = 4 * COORD_BITS + CHANNELS * COLOUR_BITS;

    localparam int M_PIXEL_X_LSB = 0;
    localparam int M_PIXEL_Y_LSB = COORD_BITS;
    localparam int M_ADDR_LSB    = 2 * COORD_BITS;
    localparam int M_COLOUR_LSB  = 2 * COORD_BITS + ADDR_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ACTIVE
    } state_t;

    typedef struct packed {
        logic load_line;
        logic div_run;
        logic step_pixel;
    } cmd_t;

    typedef struct packed {
        logic span_zero;
        logic div_done;
        logic is_last;
    } status_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]                 start_x;
        logic [COORD_BITS-1:0]                 start_y;
        logic [COORD_BITS-1:0]                 end_x;
        logic [COORD_BITS-1:0]                 end_y;
        logic [CHANNELS-1:0][COLOUR_BITS-1:0]  start_colour;
        logic [CHANNELS-1:0][COLOUR_BITS-1:0]  end_colour;
    } line_load_t;

endpackage

// ===== rtl/core/line_raster_color_interp_unit.sv =====
// Top level of the line raster colour interpolation unit.
//
// The slave channel carries two kinds of beat, told apart by s_tuser. A load beat
// (s_tuser low) gives two endpoints and their colours; it replaces any line in
// progress and gives no result. A step beat (s_tuser high) emits the next pixel of
// the active line on the master channel, with m_tlast on the final pixel; a step
// beat with no active line is taken and gives nothing.
// A load beat is taken and, unless the line has zero length, is followed by a
// division phase in which the three colour steps are divided out one
// quotient bit a cycle; s_tready is low then. Step beats are then taken one per
// cycle, and each pixel appears in the output register the cycle after its beat.
// The single output register sets the rate: when the receiver holds m_tready low,
// s_tready falls once the register is full and the pixel is held unchanged.
// The row pitch is written through cfg_wr_en and cfg_wr_data while the unit is
// idle, a rule for the user that the block does not enforce. Reset clears any
// active line and the output register and sets the row pitch to 640.
module line_raster_color_interp_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // start_x, start_y, end_x, end_y, start_red, start_green, start_blue,
    // end_red, end_green, end_blue, zero padding
    input  logic [lrci_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // kind
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_x, pixel_y, pixel_address, red, green, blue, zero padding
    output logic [lrci_pkg::M_TDATA_BITS-1:0]   m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [lrci_pkg::PITCH_BITS-1:0]     cfg_wr_data
);
    import lrci_pkg::*;

    cmd_t       cmd;
    status_t    status;
    line_load_t load;

    always_comb begin
        load.start_x = s_tdata[S_START_X_LSB +: COORD_BITS];
        load.start_y = s_tdata[S_START_Y_LSB +: COORD_BITS];
        load.end_x   = s_tdata[S_END_X_LSB +: COORD_BITS];
        load.end_y   = s_tdata[S_END_Y_LSB +: COORD_BITS];
        for (int c = 0; c < CHANNELS; c++) begin
            load.start_colour[c] = s_tdata[S_START_COL_LSB + c * COLOUR_BITS +: COLOUR_BITS];
            load.end_colour[c]   = s_tdata[S_END_COL_LSB + c * COLOUR_BITS +: COLOUR_BITS];
        end
    end

    lrci_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .kind     (s_tuser),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    lrci_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .load        (load),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .status      (status),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    a_load_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_line && !status.span_zero) |=> !s_tready)
        else $error("input taken during colour step division");

    a_step_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step_pixel |=> m_tvalid)
        else $error("stepped pixel not presented");

    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step_pixel && status.is_last) |=> !cmd.step_pixel)
        else $error("pixel stepped after the final pixel of a line");

endmodule

// ===== rtl/core/lrci_ctrl.sv =====
// Controller state machine: handshakes, line state and output register valid flag.
module lrci_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              kind,
    input  logic              m_tready,
    input  lrci_pkg::status_t status,
    output logic              s_tready,
    output logic              m_tvalid,
    output lrci_pkg::cmd_t    cmd
);
    import lrci_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg) inside
            ST_IDLE, ST_ACTIVE: begin
                if (accept && kind == KIND_LOAD) begin
                    state_next = status.span_zero ? ST_IDLE : ST_DIVIDE;
                end else if (cmd.step_pixel && status.is_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE: begin
                if (status.div_done) begin
                    state_next = ST_ACTIVE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        cmd.load_line  = 1'b0;
        cmd.div_run    = 1'b0;
        cmd.step_pixel = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_line = s_tvalid && kind == KIND_LOAD;
            end
            ST_DIVIDE: begin
                cmd.div_run = 1'b1;
            end
            ST_ACTIVE: begin
                s_tready       = !out_valid_reg || m_tready;
                cmd.load_line  = accept && kind == KIND_LOAD;
                cmd.step_pixel = accept && kind == KIND_STEP;
            end
            default: s_tready = 1'b0;
        endcase
        if (cmd.step_pixel) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/lrci_datapath.sv =====
// Datapath: endpoint ordering, colour step divider, Bresenham stepper and pixel output register.
module lrci_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lrci_pkg::cmd_t                      cmd,
    input  lrci_pkg::line_load_t                load,
    input  logic                                cfg_wr_en,
    input  logic [lrci_pkg::PITCH_BITS-1:0]     cfg_wr_data,
    output lrci_pkg::status_t                   status,
    output logic [lrci_pkg::M_TDATA_BITS-1:0]   m_tdata,
    output logic                                m_tlast
);
    import lrci_pkg::*;

    localparam int PROD_BITS = COORD_BITS + PITCH_BITS;

    function automatic logic [COORD_BITS-1:0] coord_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return (a > b) ? a - b : b - a;
    endfunction

    logic [PITCH_BITS-1:0]   pitch_reg;
    logic                    steep_reg;
    logic [COORD_BITS-1:0]   major_pos_reg, major_end_reg, minor_pos_reg;
    logic [COORD_BITS-1:0]   major_span_reg, minor_span_reg;
    logic                    minor_dir_reg;
    logic signed [ERR_BITS-1:0] error_reg;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg;
    logic [CHANNELS-1:0][COLOUR_BITS-1:0] value_reg, dividend_reg, quot_reg;
    logic [CHANNELS-1:0][COORD_BITS-1:0]  rem_reg, accum_reg;
    logic [CHANNELS-1:0]                  dir_reg;

    logic [COORD_BITS-1:0]   pixel_x_reg, pixel_y_reg;
    logic [ADDR_BITS-1:0]    addr_reg;
    logic [CHANNELS-1:0][COLOUR_BITS-1:0] colour_out_reg;
    logic                    last_reg;

    logic [COORD_BITS-1:0]   dx, dy, a0, a1, b0, b1, maj0, maj1, min0, min1, span;
    logic                    steep, swap;
    logic [CHANNELS-1:0][COLOUR_BITS-1:0] ca, cb;

    logic [COORD_BITS-1:0]   px, py;
    logic [PROD_BITS-1:0]    prod;
    logic [PROD_BITS:0]      addr_sum;
    logic [COORD_BITS:0]     major_inc;
    logic signed [ERR_BITS:0] err_sub;
    logic [CHANNELS-1:0][COORD_BITS:0] trial, acc_sum;

    always_comb begin
        dx    = coord_diff(load.start_x, load.end_x);
        dy    = coord_diff(load.start_y, load.end_y);
        steep = dy > dx;
        a0    = steep ? load.start_y : load.start_x;
        b0    = steep ? load.start_x : load.start_y;
        a1    = steep ? load.end_y   : load.end_x;
        b1    = steep ? load.end_x   : load.end_y;
        swap  = a0 > a1;
        maj0  = swap ? a1 : a0;
        maj1  = swap ? a0 : a1;
        min0  = swap ? b1 : b0;
        min1  = swap ? b0 : b1;
        ca    = swap ? load.end_colour : load.start_colour;
        cb    = swap ? load.start_colour : load.end_colour;
        span  = maj1 - maj0;
    end

    always_comb begin
        px        = steep_reg ? minor_pos_reg : major_pos_reg;
        py        = steep_reg ? major_pos_reg : minor_pos_reg;
        prod      = PROD_BITS'(py) * PROD_BITS'(pitch_reg);
        addr_sum  = {1'b0, prod} + (PROD_BITS + 1)'(px);
        major_inc = {1'b0, major_pos_reg} + (COORD_BITS + 1)'(1);
        err_sub   = {error_reg[ERR_BITS-1], error_reg}
                    - $signed((ERR_BITS + 1)'({minor_span_reg, 1'b0}));
        for (int c = 0; c < CHANNELS; c++) begin
            trial[c]   = {rem_reg[c], dividend_reg[c][div_cnt_reg]};
            acc_sum[c] = {1'b0, accum_reg[c]} + {1'b0, rem_reg[c]};
        end
    end

    assign status.span_zero = (span == '0);
    assign status.div_done  = (div_cnt_reg == '0);
    assign status.is_last   = (major_inc == {1'b0, major_end_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg   <= PITCH_RESET;
            div_cnt_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                pitch_reg <= cfg_wr_data;
            end
            if (cmd.load_line) begin
                div_cnt_reg <= DIV_CNT_BITS'(COLOUR_BITS - 1);
            end else if (cmd.div_run) begin
                div_cnt_reg <= div_cnt_reg - DIV_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_line) begin
            steep_reg      <= steep;
            major_pos_reg  <= maj0;
            major_end_reg  <= maj1;
            minor_pos_reg  <= min0;
            minor_dir_reg  <= !(min0 < min1);
            major_span_reg <= span;
            minor_span_reg <= coord_diff(min0, min1);
            error_reg      <= $signed(ERR_BITS'(span));
            for (int c = 0; c < CHANNELS; c++) begin
                value_reg[c]    <= ca[c];
                dir_reg[c]      <= cb[c] < ca[c];
                dividend_reg[c] <= (ca[c] > cb[c]) ? ca[c] - cb[c] : cb[c] - ca[c];
                quot_reg[c]     <= '0;
                rem_reg[c]      <= '0;
                accum_reg[c]    <= '0;
            end
        end else if (cmd.div_run) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (trial[c] >= {1'b0, major_span_reg}) begin
                    rem_reg[c]  <= COORD_BITS'(trial[c] - {1'b0, major_span_reg});
                    quot_reg[c] <= {quot_reg[c][COLOUR_BITS-2:0], 1'b1};
                end else begin
                    rem_reg[c]  <= COORD_BITS'(trial[c]);
                    quot_reg[c] <= {quot_reg[c][COLOUR_BITS-2:0], 1'b0};
                end
            end
        end else if (cmd.step_pixel) begin
            major_pos_reg <= COORD_BITS'(major_inc);
            if (err_sub < 0) begin
                minor_pos_reg <= minor_dir_reg ? minor_pos_reg - COORD_BITS'(1)
                                               : minor_pos_reg + COORD_BITS'(1);
                error_reg <= ERR_BITS'(err_sub
                             + $signed((ERR_BITS + 1)'({major_span_reg, 1'b0})));
            end else begin
                error_reg <= ERR_BITS'(err_sub);
            end
            for (int c = 0; c < CHANNELS; c++) begin
                if (acc_sum[c] >= {1'b0, major_span_reg}) begin
                    accum_reg[c] <= COORD_BITS'(acc_sum[c] - {1'b0, major_span_reg});
                    value_reg[c] <= dir_reg[c] ? value_reg[c] - quot_reg[c] - 8'd1
                                               : value_reg[c] + quot_reg[c] + 8'd1;
                end else begin
                    accum_reg[c] <= COORD_BITS'(acc_sum[c]);
                    value_reg[c] <= dir_reg[c] ? value_reg[c] - quot_reg[c]
                                               : value_reg[c] + quot_reg[c];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_pixel) begin
            pixel_x_reg    <= px;
            pixel_y_reg    <= py;
            addr_reg       <= ADDR_BITS'(addr_sum);
            colour_out_reg <= value_reg;
            last_reg       <= status.is_last;
        end
    end

    always_comb begin
        m_tdata = '0;
        m_tdata[M_PIXEL_X_LSB +: COORD_BITS] = pixel_x_reg;
        m_tdata[M_PIXEL_Y_LSB +: COORD_BITS] = pixel_y_reg;
        m_tdata[M_ADDR_LSB +: ADDR_BITS]     = addr_reg;
        for (int c = 0; c < CHANNELS; c++) begin
            m_tdata[M_COLOUR_LSB + c * COLOUR_BITS +: COLOUR_BITS] = colour_out_reg[c];
        end
    end

    assign m_tlast = last_reg;

endmodule
